@@ rtl/core/dsm_pkg.sv @@
package dsm_pkg;

	// Parameter defaults
	localparam int MAX_POINTS_DEF  = 1024;
	localparam int MAX_GATES_DEF   = 256;
	localparam int POWER_WIDTH_DEF = 32;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int NP_W       = 11;
	localparam int NG_W       = 9;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_GATES  = 2'd1;

	localparam logic [NP_W-1:0] NP_RESET = 11'd256;
	localparam logic [NG_W-1:0] NG_RESET = 9'd64;

	// Word field widths
	localparam int PIN_W   = 32;
	localparam int GATE_W  = 8;
	localparam int TOTAL_W = 42;
	localparam int PEAK_W  = 32;
	localparam int MEAN_W  = 18;
	localparam int MOM_W   = 52;
	localparam int FRAC_W  = 8;

	// Divider: one quotient bit per step, quotient as wide as the mean
	localparam int QUO_W     = MEAN_W;
	localparam int DIV_STEPS = QUO_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [QUO_W-1:0] MEAN_POS_MAX = 18'd131071;
	localparam logic [QUO_W-1:0] MEAN_NEG_MAX = 18'd131072;

	localparam int QUEUE_DEPTH = 2;

	// One finished gate, handed from the accumulator to the divider
	typedef struct packed {
		logic [GATE_W-1:0]  gate;
		logic [TOTAL_W-1:0] total;
		logic [PEAK_W-1:0]  peak;
		logic               neg;
		logic [MOM_W-1:0]   mag;
		logic               last;
	} gate_rec_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_DIV,
		DS_DONE
	} div_state_t;

endpackage

@@ rtl/core/dsm_front.sv @@
module dsm_front #(
	parameter int MAX_POINTS  = dsm_pkg::MAX_POINTS_DEF,
	parameter int MAX_GATES   = dsm_pkg::MAX_GATES_DEF,
	parameter int POWER_WIDTH = dsm_pkg::POWER_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [dsm_pkg::PIN_W-1:0] power,
	input  logic [dsm_pkg::NP_W-1:0]  num_points,
	input  logic [dsm_pkg::NG_W-1:0]  num_gates,
	input  logic                      q_full,
	output logic                      push,
	output dsm_pkg::gate_rec_t        rec
);

	localparam int PIW   = $clog2(MAX_POINTS);
	localparam int NW    = $clog2(MAX_POINTS + 1);
	localparam int CW    = (NW > dsm_pkg::NP_W) ? NW : dsm_pkg::NP_W;
	localparam int GCW   = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;
	localparam int GW    = $clog2(MAX_GATES + 1);
	localparam int GCMPW = ((GW > dsm_pkg::NG_W) ? GW : dsm_pkg::NG_W) + 1;
	localparam int PRODW = NW + POWER_WIDTH;

	logic [PIW-1:0]                 point_q;
	logic [GCW-1:0]                 gate_q;
	logic [dsm_pkg::TOTAL_W-1:0]    psum_q;
	logic [dsm_pkg::MOM_W-1:0]      msum_q;
	logic [POWER_WIDTH-1:0]         peak_q;
	logic [POWER_WIDTH-1:0]         first_q;

	logic [CW-1:0]                  np_ext, np_clamp;
	logic [NW-1:0]                  n_tmp, n_eff, half_n, k_ext, wmag;
	logic                           wneg;
	logic [NW:0]                    k_inc;
	logic                           close;
	logic [GCMPW-1:0]               g_ext, g_eff, gc_inc;
	logic                           last;
	logic [POWER_WIDTH-1:0]         p;
	logic [PRODW-1:0]               prod;
	logic [dsm_pkg::TOTAL_W-1:0]    psum_n;
	logic [dsm_pkg::MOM_W-1:0]      msum_n;
	logic [POWER_WIDTH-1:0]         first_n, peak_n, dc, peak_out;
	logic [POWER_WIDTH:0]           dc_sum;
	logic [GCW+dsm_pkg::GATE_W-1:0] gate_ext;
	logic                           accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign p        = power[POWER_WIDTH-1:0];

	// Effective gate length: clamp, then force even
	always_comb begin
		np_ext = CW'(num_points);
		if (np_ext < CW'(4)) begin
			np_clamp = CW'(4);
		end else if (np_ext > CW'(MAX_POINTS)) begin
			np_clamp = CW'(MAX_POINTS);
		end else begin
			np_clamp = np_ext;
		end
		n_tmp  = NW'(np_clamp);
		n_eff  = {n_tmp[NW-1:1], 1'b0};
		half_n = n_eff >> 1;
	end

	always_comb begin
		g_ext = GCMPW'(num_gates);
		if (g_ext < GCMPW'(1)) begin
			g_eff = GCMPW'(1);
		end else if (g_ext > GCMPW'(MAX_GATES)) begin
			g_eff = GCMPW'(MAX_GATES);
		end else begin
			g_eff = g_ext;
		end
		gc_inc = GCMPW'(gate_q) + GCMPW'(1);
		last   = gc_inc >= g_eff;
	end

	// Shifted bin weight: upper half counts negative
	always_comb begin
		k_ext = NW'(point_q);
		if (k_ext < half_n) begin
			wmag = k_ext;
			wneg = 1'b0;
		end else if (k_ext < n_eff) begin
			wmag = n_eff - k_ext;
			wneg = 1'b1;
		end else begin
			wmag = k_ext - n_eff;
			wneg = 1'b0;
		end
		k_inc = {1'b0, k_ext} + (NW+1)'(1);
		close = k_inc >= {1'b0, n_eff};
	end

	always_comb begin
		prod    = PRODW'(wmag) * PRODW'(p);
		psum_n  = psum_q + dsm_pkg::TOTAL_W'(p);
		msum_n  = wneg ? msum_q - dsm_pkg::MOM_W'(prod) : msum_q + dsm_pkg::MOM_W'(prod);
		first_n = (k_ext == NW'(1)) ? p : first_q;
		peak_n  = ((k_ext != '0) && (p > peak_q)) ? p : peak_q;
		// DC stand-in: truncated mean of the two neighbours
		dc_sum   = {1'b0, first_n} + {1'b0, p};
		dc       = dc_sum[POWER_WIDTH:1];
		peak_out = (peak_n > dc) ? peak_n : dc;
		gate_ext = {{dsm_pkg::GATE_W{1'b0}}, gate_q};
	end

	always_comb begin
		rec.gate  = gate_ext[dsm_pkg::GATE_W-1:0];
		rec.total = psum_n;
		rec.peak  = dsm_pkg::PEAK_W'(peak_out);
		rec.neg   = msum_n[dsm_pkg::MOM_W-1];
		rec.mag   = msum_n[dsm_pkg::MOM_W-1] ? (~msum_n + dsm_pkg::MOM_W'(1)) : msum_n;
		rec.last  = last;
	end

	assign push = accept && close;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_q <= '0;
			gate_q  <= '0;
			psum_q  <= '0;
			msum_q  <= '0;
			peak_q  <= '0;
			first_q <= '0;
		end else if (accept) begin
			if (close) begin
				point_q <= '0;
				gate_q  <= last ? '0 : GCW'(gc_inc);
				psum_q  <= '0;
				msum_q  <= '0;
				peak_q  <= '0;
				first_q <= '0;
			end else begin
				point_q <= PIW'(k_inc);
				psum_q  <= psum_n;
				msum_q  <= msum_n;
				peak_q  <= peak_n;
				first_q <= first_n;
			end
		end
	end

endmodule

@@ rtl/core/dsm_queue.sv @@
module dsm_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dsm_pkg::gate_rec_t din,
	input  logic               pop,
	output dsm_pkg::gate_rec_t dout,
	output logic               full,
	output logic               empty
);

	localparam int DEPTH = dsm_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CTW   = $clog2(DEPTH + 1);

	dsm_pkg::gate_rec_t entry_q [DEPTH];
	logic [PW-1:0]      wr_q, rd_q;
	logic [CTW-1:0]     count_q;
	logic               do_push, do_pop;

	assign full    = count_q == CTW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CTW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CTW'(1);
			end
		end
	end

endmodule

@@ rtl/core/dsm_back.sv @@
module dsm_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  dsm_pkg::gate_rec_t                q_rec,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dsm_pkg::GATE_W-1:0]        gate_number,
	output logic [dsm_pkg::TOTAL_W-1:0]       total_power,
	output logic [dsm_pkg::PEAK_W-1:0]        peak_power,
	output logic signed [dsm_pkg::MEAN_W-1:0] mean_bin,
	output logic                              zero_power,
	output logic                              last_gate
);

	localparam int TW  = dsm_pkg::TOTAL_W;
	localparam int QW  = dsm_pkg::QUO_W;
	localparam int DVW = dsm_pkg::MOM_W + dsm_pkg::FRAC_W;

	dsm_pkg::div_state_t state_q, state_n;

	logic [dsm_pkg::GATE_W-1:0] gate_q;
	logic [TW-1:0]              total_q, rem_q;
	logic [dsm_pkg::PEAK_W-1:0] peak_q;
	logic                       neg_q, last_q, zero_q, sat_q;
	logic [QW-1:0]              low_q, quo_q;
	logic [dsm_pkg::CNT_W-1:0]  cnt_q;

	logic                       load, step, emit, out_free;
	logic [DVW-1:0]             dvd;
	logic [TW-1:0]              dvd_hi;
	logic                       ld_zero, ld_ovf;
	logic [TW:0]                trial, diff;
	logic                       ge;
	logic [QW-1:0]              q_raw, q_clip, mean_n;

	logic                       out_valid_q;
	logic [dsm_pkg::GATE_W-1:0] gate_o_q;
	logic [TW-1:0]              total_o_q;
	logic [dsm_pkg::PEAK_W-1:0] peak_o_q;
	logic [QW-1:0]              mean_o_q;
	logic                       zero_o_q, last_o_q;

	assign out_free = !out_valid_q || out_ready;

	// Dividend is the moment magnitude with eight fraction bits appended
	always_comb begin
		dvd     = {q_rec.mag, {dsm_pkg::FRAC_W{1'b0}}};
		dvd_hi  = dvd[DVW-1 -: TW];
		ld_zero = q_rec.total == '0;
		ld_ovf  = dvd_hi >= q_rec.total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsm_pkg::DS_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		load    = 1'b0;
		step    = 1'b0;
		emit    = 1'b0;
		unique case (state_q)
			dsm_pkg::DS_IDLE: begin
				if (!q_empty) begin
					load    = 1'b1;
					state_n = (ld_zero || ld_ovf) ? dsm_pkg::DS_DONE : dsm_pkg::DS_DIV;
				end
			end
			dsm_pkg::DS_DIV: begin
				step = 1'b1;
				if (cnt_q == '0) begin
					state_n = dsm_pkg::DS_DONE;
				end
			end
			dsm_pkg::DS_DONE: begin
				if (out_free) begin
					emit    = 1'b1;
					state_n = dsm_pkg::DS_IDLE;
				end
			end
			default: begin
				state_n = dsm_pkg::DS_IDLE;
			end
		endcase
	end

	assign pop = load;

	// Restoring step: bring down one dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, low_q[QW-1]};
		diff  = trial - {1'b0, total_q};
		ge    = trial >= {1'b0, total_q};
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gate_q  <= q_rec.gate;
			total_q <= q_rec.total;
			peak_q  <= q_rec.peak;
			neg_q   <= q_rec.neg;
			last_q  <= q_rec.last;
			zero_q  <= ld_zero;
			sat_q   <= ld_ovf;
			rem_q   <= dvd_hi;
			low_q   <= dvd[QW-1:0];
			quo_q   <= '0;
			cnt_q   <= dsm_pkg::CNT_W'(dsm_pkg::DIV_STEPS - 1);
		end else if (step) begin
			rem_q <= ge ? diff[TW-1:0] : trial[TW-1:0];
			low_q <= {low_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], ge};
			cnt_q <= cnt_q - dsm_pkg::CNT_W'(1);
		end
	end

	// Saturate, then apply the sign; a zero total forces the mean to zero
	always_comb begin
		q_raw = sat_q ? {QW{1'b1}} : quo_q;
		if (neg_q) begin
			q_clip = (q_raw > dsm_pkg::MEAN_NEG_MAX) ? dsm_pkg::MEAN_NEG_MAX : q_raw;
			mean_n = ~q_clip + QW'(1);
		end else begin
			q_clip = (q_raw > dsm_pkg::MEAN_POS_MAX) ? dsm_pkg::MEAN_POS_MAX : q_raw;
			mean_n = q_clip;
		end
		if (zero_q) begin
			mean_n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			gate_o_q  <= gate_q;
			total_o_q <= total_q;
			peak_o_q  <= peak_q;
			mean_o_q  <= mean_n;
			zero_o_q  <= zero_q;
			last_o_q  <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign gate_number = gate_o_q;
	assign total_power = total_o_q;
	assign peak_power  = peak_o_q;
	assign mean_bin    = $signed(mean_o_q);
	assign zero_power  = zero_o_q;
	assign last_gate   = last_o_q;

endmodule

@@ rtl/core/doppler_spectral_moments.sv @@
// Doppler spectral moments per range gate.
// Input channel (in_valid/in_ready/power): one power-spectrum point per word, FFT order,
// num_points words per gate. Points are taken at one per cycle while the gate queue has room.
// Output channel (out_valid/out_ready): one word per gate with gate number, total power,
// peak (DC swapped for the mean of its neighbours), mean Doppler bin in signed Q.8 and the
// zero-power and last-gate flags.
// Path: once the last point of a gate is accepted, the gate is picked up from the gate queue,
// run through the bit-serial divider and registered in the output register; a zero total
// or a saturating mean skips the divider.
// Throughput: the accumulator front takes a point every cycle while the queue has room; the
// divider back end takes no new gate until it is done with the last, so gates shorter than a
// division back up into the two-entry queue and then hold in_ready low.
// Configuration: cfg_we/cfg_index/cfg_data write num_points (index 0) and num_gates
// (index 1) at once; write them only while no gate result is outstanding.
// Reset: clears the accumulators and gate counter, empties the queue, drops output valid and loads
// num_points = 256, num_gates = 64. No clearing pass follows.
// Receiver stall: the result waits in the output register while the divider finishes the
// next gate; once both wait and the queue fills, the front stops taking points.
module doppler_spectral_moments #(
	parameter int MAX_POINTS  = dsm_pkg::MAX_POINTS_DEF,
	parameter int MAX_GATES   = dsm_pkg::MAX_GATES_DEF,
	parameter int POWER_WIDTH = dsm_pkg::POWER_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [dsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [dsm_pkg::PIN_W-1:0]         power,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dsm_pkg::GATE_W-1:0]        gate_number,
	output logic [dsm_pkg::TOTAL_W-1:0]       total_power,
	output logic [dsm_pkg::PEAK_W-1:0]        peak_power,
	output logic signed [dsm_pkg::MEAN_W-1:0] mean_bin,
	output logic                              zero_power,
	output logic                              last_gate
);

	logic [dsm_pkg::NP_W-1:0] num_points_q;
	logic [dsm_pkg::NG_W-1:0] num_gates_q;

	dsm_pkg::gate_rec_t push_rec, head_rec;
	logic               push, pop, q_full, q_empty;

	// Register writes: keep only the bits each register holds, drop other indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_points_q <= dsm_pkg::NP_RESET;
			num_gates_q  <= dsm_pkg::NG_RESET;
		end else if (cfg_we) begin
			if (cfg_index == dsm_pkg::REG_NUM_POINTS) begin
				num_points_q <= cfg_data[dsm_pkg::NP_W-1:0];
			end else if (cfg_index == dsm_pkg::REG_NUM_GATES) begin
				num_gates_q <= cfg_data[dsm_pkg::NG_W-1:0];
			end
		end
	end

	// Front: accumulate power, moment and peak, close the gate
	dsm_front #(
		.MAX_POINTS  (MAX_POINTS),
		.MAX_GATES   (MAX_GATES),
		.POWER_WIDTH (POWER_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.power      (power),
		.num_points (num_points_q),
		.num_gates  (num_gates_q),
		.q_full     (q_full),
		.push       (push),
		.rec        (push_rec)
	);

	// Hold finished gates between front and divider
	dsm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_rec),
		.pop    (pop),
		.dout   (head_rec),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back: divide moment by power, saturate, register the result
	dsm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_rec       (head_rec),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.gate_number (gate_number),
		.total_power (total_power),
		.peak_power  (peak_power),
		.mean_bin    (mean_bin),
		.zero_power  (zero_power),
		.last_gate   (last_gate)
	);

endmodule

@@ rtl/core/dsm_checker.sv @@
module dsm_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              cfg_we,
	input logic [dsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input logic [dsm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [dsm_pkg::PIN_W-1:0]         power,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [dsm_pkg::GATE_W-1:0]        gate_number,
	input logic [dsm_pkg::TOTAL_W-1:0]       total_power,
	input logic [dsm_pkg::PEAK_W-1:0]        peak_power,
	input logic signed [dsm_pkg::MEAN_W-1:0] mean_bin,
	input logic                              zero_power,
	input logic                              last_gate
);

	// Stalled result word holds: gate, total, peak and mean stay stable
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_power) && $stable(mean_bin)
		&& $stable(gate_number) && $stable(peak_power))
		else $error("result word changed while stalled");

	// Zero flag tracks an empty gate exactly
	a_zero_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (zero_power == (total_power == '0)))
		else $error("zero_power disagrees with total_power");

	// Empty gate forces the mean to zero
	a_zero_mean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_power |-> mean_bin == '0)
		else $error("mean_bin not zero on empty gate");

	// Peak never exceeds the gate total
	a_peak_total: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(dsm_pkg::TOTAL_W'(peak_power) > total_power))
		else $error("peak_power above total_power");

endmodule

bind doppler_spectral_moments dsm_checker u_dsm_checker (.*);

@@ dv/doppler_spectral_moments_tb.sv @@
module doppler_spectral_moments_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsm_pkg::*;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 9;
	// The divider path needs time after the last point of a gate; allow a margin.
	localparam int SETTLE_CYCLES  = 30;
	// Longest correct quiet spell is a settle plus a config write, well under this.
	localparam int STALL_LIMIT    = 2000;
	localparam int TARGET_POINTS  = 2000;
	localparam int CALM_POINTS    = 1700;
	localparam int PRINT_LIMIT    = 200;

	// One gate result as it leaves the block
	typedef struct packed {
		logic [GATE_W-1:0]  gate;
		logic [TOTAL_W-1:0] total;
		logic [PEAK_W-1:0]  peak;
		logic [MEAN_W-1:0]  mean;
		logic               zero;
		logic               closes;
	} gate_result_t;

	// Spectrum shapes drawn for the points of one gate
	typedef enum {
		SHAPE_FULL,
		SHAPE_SMALL,
		SHAPE_ZERO,
		SHAPE_HIGH,
		SHAPE_SPIKE
	} power_shape_t;

	// Gate moments predictor plus the queue of gate results still due
	class moments_scoreboard;
		logic [NP_W-1:0]    points_reg;
		logic [NG_W-1:0]    gates_reg;
		int unsigned        point_idx;
		logic [GATE_W-1:0]  gate_cnt;
		logic [TOTAL_W-1:0] power_acc;
		logic [MOM_W-1:0]   moment_acc;
		logic [PEAK_W-1:0]  peak_acc;
		logic [PEAK_W-1:0]  bin1_power;
		gate_result_t       gates_due[$];
		int                 errors;

		function new();
			points_reg = NP_RESET;
			gates_reg  = NG_RESET;
			gate_cnt   = '0;
			errors     = 0;
			clear_gate();
		endfunction

		function void clear_gate();
			point_idx  = 0;
			power_acc  = '0;
			moment_acc = '0;
			peak_acc   = '0;
			bin1_power = '0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_NUM_POINTS: points_reg = data[NP_W-1:0];
				REG_NUM_GATES:  gates_reg  = data[NG_W-1:0];
				default: ;
			endcase
		endfunction

		// Points per gate after clamping and forcing even
		function int unsigned gate_length();
			int unsigned n;
			n = 32'(points_reg);
			if (n < 4) n = 4;
			if (n > MAX_POINTS_DEF) n = MAX_POINTS_DEF;
			return n & ~32'd1;
		endfunction

		function void note_point(logic [PIN_W-1:0] p);
			int unsigned      n;
			int unsigned      g;
			int unsigned      k;
			logic [63:0]      wmag;
			logic [63:0]      prod;
			logic [63:0]      num;
			logic [63:0]      quo;
			logic             wneg;
			logic             neg;
			logic             closes;
			logic [MOM_W-1:0] mag;
			logic [PEAK_W:0]  pair;
			logic [PEAK_W-1:0] dc;
			gate_result_t     r;

			n = gate_length();
			g = 32'(gates_reg);
			if (g < 1) g = 1;
			if (g > MAX_GATES_DEF) g = MAX_GATES_DEF;
			k = point_idx;

			power_acc = power_acc + {{(TOTAL_W-PIN_W){1'b0}}, p};

			// FFT-shifted bin weight: upper half runs from -N/2 up to -1
			if (k < n / 2) begin
				wmag = 64'(k);
				wneg = 1'b0;
			end else if (k < n) begin
				wmag = 64'(n - k);
				wneg = 1'b1;
			end else begin
				wmag = 64'(k - n);
				wneg = 1'b0;
			end
			prod = wmag * {32'b0, p};
			if (wneg) moment_acc = moment_acc - prod[MOM_W-1:0];
			else moment_acc = moment_acc + prod[MOM_W-1:0];

			if (k == 1) bin1_power = p;
			if (k != 0 && p > peak_acc) peak_acc = p;

			if (k + 1 < n) begin
				point_idx = k + 1;
				return;
			end

			// DC bin stands in for the peak as the truncated mean of its neighbours
			pair = {1'b0, bin1_power} + {1'b0, p};
			dc   = pair[PEAK_W:1];

			closes   = (32'(gate_cnt) + 1 >= g);
			r.gate   = gate_cnt;
			r.total  = power_acc;
			r.peak   = (peak_acc > dc) ? peak_acc : dc;
			r.zero   = (power_acc == 0);
			r.closes = closes;
			r.mean   = '0;
			if (power_acc != 0) begin
				neg = moment_acc[MOM_W-1];
				mag = neg ? -moment_acc : moment_acc;
				num = {4'b0, mag, 8'b0};
				quo = num / {22'b0, power_acc};
				if (neg) begin
					if (quo > 64'(MEAN_NEG_MAX)) quo = 64'(MEAN_NEG_MAX);
					r.mean = -quo[MEAN_W-1:0];
				end else begin
					if (quo > 64'(MEAN_POS_MAX)) quo = 64'(MEAN_POS_MAX);
					r.mean = quo[MEAN_W-1:0];
				end
			end
			gates_due.push_back(r);

			gate_cnt = closes ? '0 : gate_cnt + 1'b1;
			clear_gate();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_LIMIT) $display("ERROR: %s", msg);
		endtask

		function string field_line(string name, logic [GATE_W-1:0] gate,
				logic [63:0] want, logic [63:0] got);
			return $sformatf("gate %0d %s: expected %0h, got %0h", gate, name, want, got);
		endfunction

		task check_gate(gate_result_t got);
			gate_result_t want;
			if (gates_due.size() == 0) begin
				report($sformatf("unexpected result word: gate %0h total %0h",
					got.gate, got.total));
				return;
			end
			want = gates_due.pop_front();
			if (got.gate !== want.gate)
				report(field_line("gate_number", want.gate, 64'(want.gate), 64'(got.gate)));
			if (got.total !== want.total)
				report(field_line("total_power", want.gate, 64'(want.total), 64'(got.total)));
			if (got.peak !== want.peak)
				report(field_line("peak_power", want.gate, 64'(want.peak), 64'(got.peak)));
			if (got.mean !== want.mean)
				report(field_line("mean_bin", want.gate, 64'(want.mean), 64'(got.mean)));
			if (got.zero !== want.zero)
				report(field_line("zero_power", want.gate, 64'(want.zero), 64'(got.zero)));
			if (got.closes !== want.closes)
				report(field_line("last_gate", want.gate, 64'(want.closes), 64'(got.closes)));
		endtask
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]     cfg_index = REG_NUM_POINTS;
	logic [CFG_DATA_W-1:0]    cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic [PIN_W-1:0]         power = '0;
	logic                     out_valid;
	logic                     out_ready;
	logic [GATE_W-1:0]        gate_number;
	logic [TOTAL_W-1:0]       total_power;
	logic [PEAK_W-1:0]        peak_power;
	logic signed [MEAN_W-1:0] mean_bin;
	logic                     zero_power;
	logic                     last_gate;

	moments_scoreboard sb = new();

	// Handshake flags sampled mid-cycle: high means the word moves at the next rising edge
	logic         in_take = 1'b0;
	logic         out_take = 1'b0;
	gate_result_t gate_word;
	int           quiet_cycles = 0;
	int           points_sent = 0;
	// Set for the closing stretch of the run: no idling on either side
	logic         calm = 1'b0;

	doppler_spectral_moments u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.power       (power),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.gate_number (gate_number),
		.total_power (total_power),
		.peak_power  (peak_power),
		.mean_bin    (mean_bin),
		.zero_power  (zero_power),
		.last_gate   (last_gate)
	);

	always #CLK_HALF clk = ~clk;

	// Sample both channels on the falling edge, where every signal is settled.
	// Feed accepted points to the predictor before checking results, and count
	// cycles in which no word moves on either side.
	always @(negedge clk) begin
		in_take  = in_valid && in_ready;
		out_take = out_valid && out_ready;
		gate_word = {gate_number, total_power, peak_power, mean_bin, zero_power, last_gate};
		if (in_take) sb.note_point(power);
		if (out_take) sb.check_gate(gate_word);
		if (in_take || out_take) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("doppler_spectral_moments regression: fail");
			$finish;
		end
	end

	// Receiver: stall in random bursts, otherwise take every word
	always begin
		if (!calm && $urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		out_ready <= 1'b1;
		@(posedge clk);
	end

	// Offer one point and hold it until the block takes it; idle first now and then
	task automatic send_point(logic [PIN_W-1:0] p);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		power    <= p;
		do @(posedge clk); while (!in_take);
		points_sent++;
		if (points_sent >= CALM_POINTS) calm = 1'b1;
	endtask

	task automatic send_gate4(logic [PIN_W-1:0] a, logic [PIN_W-1:0] b,
			logic [PIN_W-1:0] c, logic [PIN_W-1:0] d);
		send_point(a);
		send_point(b);
		send_point(c);
		send_point(d);
	endtask

	// Drop valid, wait for every gate result due, then let the back end go quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.gates_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; call only while the block is idle
	task automatic configure(logic [CFG_DATA_W-1:0] np_val, logic [CFG_DATA_W-1:0] ng_val);
		cfg_we    <= 1'b1;
		cfg_index <= REG_NUM_POINTS;
		cfg_data  <= np_val;
		sb.set_register(REG_NUM_POINTS, np_val);
		@(posedge clk);
		cfg_index <= REG_NUM_GATES;
		cfg_data  <= ng_val;
		sb.set_register(REG_NUM_GATES, ng_val);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One setting: whole gates of shaped spectra, optionally ending part way into a gate
	task automatic run_phase(logic [CFG_DATA_W-1:0] np_val, logic [CFG_DATA_W-1:0] ng_val,
			int unsigned gates, logic partial);
		int unsigned       len;
		int unsigned       total;
		int unsigned       i;
		int unsigned       r;
		int unsigned       spike_bin;
		power_shape_t      shape;
		logic [PIN_W-1:0]  p;

		configure(np_val, ng_val);
		len   = sb.gate_length();
		total = gates * len + (partial ? $urandom_range(1, len - 1) : 0);
		shape = SHAPE_FULL;
		spike_bin = 0;
		for (i = 0; i < total; i++) begin
			// Pick a fresh shape whenever a gate starts
			if (sb.point_idx == 0) begin
				r = $urandom_range(0, 15);
				shape = (r < 6) ? SHAPE_FULL : (r < 9) ? SHAPE_SMALL : (r < 10) ? SHAPE_ZERO :
					(r < 12) ? SHAPE_HIGH : SHAPE_SPIKE;
				spike_bin = $urandom_range(0, len - 1);
			end
			case (shape)
				SHAPE_SMALL: p = PIN_W'($urandom_range(0, 255));
				SHAPE_ZERO:  p = '0;
				SHAPE_HIGH:  p = $urandom | 32'hFFFF_0000;
				SHAPE_SPIKE: p = (sb.point_idx == spike_bin) ? $urandom : '0;
				default:     p = $urandom;
			endcase
			send_point(p);
		end
		settle();
	endtask

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] np_val;
		logic [CFG_DATA_W-1:0] ng_val;
		int unsigned           gates;
		int unsigned           pick;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: a partial 256-point gate with extreme values, left open
		send_point(32'hFFFF_FFFF);
		send_point(32'h0000_0001);
		send_point(32'h8000_0000);
		settle();

		// Shrink the gate under the open one: the next point closes it at once.
		// A gates value of zero behaves as one, so every gate is the last.
		configure(11'd4, 11'd0);
		send_point(32'h0000_FFFF);
		// All-zero gate flags zero power; all-ones gate hits the largest sums
		send_gate4(32'h0, 32'h0, 32'h0, 32'h0);
		send_gate4(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_gate4(32'h1234_5678, 32'h0001_0000, 32'h0, 32'h0003_0000);
		settle();

		// Points below the minimum clamp to four; gates above the maximum clamp down
		configure(11'd1, 11'd511);
		send_gate4(32'h0, 32'h0, 32'h0, 32'h5);
		settle();

		// Odd points value loses its low bit; gates value beyond nine bits is truncated
		configure(11'd5, 11'd2047);
		send_gate4(32'h0, 32'h7, 32'h0, 32'h0);
		settle();

		// Full-length gate with the points value clamped from above
		run_phase(CFG_DATA_W'($urandom_range(1025, 2047)), CFG_DATA_W'($urandom_range(0, 2047)),
			1, 1'b0);

		// Mostly short gates so results stay frequent; now and then a long one
		while (points_sent < TARGET_POINTS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0) begin
				np_val = CFG_DATA_W'($urandom_range(65, 1024));
				gates  = 1;
			end else if (pick < 8) begin
				np_val = CFG_DATA_W'($urandom_range(0, 12));
				gates  = $urandom_range(1, 8);
			end else begin
				np_val = CFG_DATA_W'($urandom_range(13, 64));
				gates  = $urandom_range(1, 6);
			end
			case ($urandom_range(0, 3))
				0:       ng_val = CFG_DATA_W'($urandom_range(0, 3));
				1:       ng_val = CFG_DATA_W'($urandom_range(4, 16));
				2:       ng_val = CFG_DATA_W'($urandom_range(17, 511));
				default: ng_val = CFG_DATA_W'($urandom_range(0, 2047));
			endcase
			run_phase(np_val, ng_val, gates, $urandom_range(0, 3) == 0);
		end

		if (sb.errors == 0) $display("doppler_spectral_moments regression: pass");
		else $display("doppler_spectral_moments regression: fail");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/dsm_pkg.sv
rtl/core/dsm_front.sv
rtl/core/dsm_queue.sv
rtl/core/dsm_back.sv
rtl/core/doppler_spectral_moments.sv
rtl/core/dsm_checker.sv
dv/doppler_spectral_moments_tb.sv
